### hdl/stepper_homing_sequencer_core_assert.svh
// Assertion helpers for the homing sequencer.
// Each check is sampled on the rising clock edge and is off while reset is held.
`ifndef STEPPER_HOMING_SEQUENCER_CORE_ASSERT_SVH
`define STEPPER_HOMING_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SHS_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication.
`define SHS_ASSERT_NXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### hdl/shs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package shs_pkg;

  // time stamps and timeouts
  localparam int TIME_W = 32;

  // command codes
  localparam logic [1:0] CMD_EVAL  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_DIST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOWARD_TO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AWAY_TO     = 3'd6;

  // reset values of the timing registers
  localparam logic [TIME_W-1:0] SETTLE_RST    = TIME_W'(1000000);
  localparam logic [TIME_W-1:0] TIMEOUT_RST   = TIME_W'(2 * 60000000);

  // divide by five: floor(x * RECIP5 / 2^RECIP5_SH) exact for 24-bit x
  localparam int              RECIP5_SH = 27;
  localparam logic [24:0]     RECIP5    = 25'd26843546;

  // phase codes seen on the result word
  localparam logic [2:0] PC_IDLE   = 3'd0;
  localparam logic [2:0] PC_TOWARD = 3'd1;
  localparam logic [2:0] PC_DELAY1 = 3'd2;
  localparam logic [2:0] PC_AWAY   = 3'd3;
  localparam logic [2:0] PC_DELAY2 = 3'd4;
  localparam logic [2:0] PC_ADJUST = 3'd5;
  localparam logic [2:0] PC_DELAY3 = 3'd6;
  localparam logic [2:0] PC_ERROR  = 3'd7;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_TOWARD = 8'b0000_0010,
    PH_DELAY1 = 8'b0000_0100,
    PH_AWAY   = 8'b0000_1000,
    PH_DELAY2 = 8'b0001_0000,
    PH_ADJUST = 8'b0010_0000,
    PH_DELAY3 = 8'b0100_0000,
    PH_ERROR  = 8'b1000_0000
  } phase_t;

  // map the internal phase to its 3-bit code
  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE:   code = PC_IDLE;
      PH_TOWARD: code = PC_TOWARD;
      PH_DELAY1: code = PC_DELAY1;
      PH_AWAY:   code = PC_AWAY;
      PH_DELAY2: code = PC_DELAY2;
      PH_ADJUST: code = PC_ADJUST;
      PH_DELAY3: code = PC_DELAY3;
      PH_ERROR:  code = PC_ERROR;
      default:   code = PC_IDLE;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

### hdl/shs_if.sv
`timescale 1ns / 1ps
`default_nettype none

// command word channel
interface shs_in_if;
  import shs_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [TIME_W-1:0] now_us;
  logic              limit_switch;
  logic              fault;
  logic              motion_busy;

  modport source (output valid, command, now_us, limit_switch, fault, motion_busy,
                  input ready);
  modport sink   (input valid, command, now_us, limit_switch, fault, motion_busy,
                  output ready);
endinterface

// action word channel
interface shs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         phase;
  logic               jog_valid;
  logic signed [24:0] jog_speed;
  logic               stop_motor;
  logic               restore_defaults;
  logic               move_valid;
  logic signed [31:0] move_distance;
  logic               set_position_valid;
  logic signed [31:0] set_position_value;
  logic               homed;

  modport source (output valid, phase, jog_valid, jog_speed, stop_motor, restore_defaults,
                         move_valid, move_distance, set_position_valid,
                         set_position_value, homed,
                  input ready);
  modport sink   (input valid, phase, jog_valid, jog_speed, stop_motor, restore_defaults,
                        move_valid, move_distance, set_position_valid,
                        set_position_value, homed,
                  output ready);
endinterface
`default_nettype wire

### hdl/stepper_homing_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Homing sequencer for one stepper axis.
// in_ch carries command words (evaluate, start, stop) with the current microsecond
// time and the limit, fault and busy levels. out_ch returns one action word per
// command word: the phase after it, the homed flag and one-word pulses for jog,
// stop, restore defaults, relative move and set position.
// cfg_we/cfg_index/cfg_wdata write the setup registers; write them only while no
// word is in flight.
// A word taken on in_ch passes the input register, then the result register, and
// then shows on out_ch. Throughput: one word per cycle while out_ch keeps taking
// words; the phase, phase start and homed registers are updated in the same cycle
// the word moves to the result register, so a following word sees them at once.
// Stall: when out_ch is not taken, the result holds and one more word may wait
// in the input register; in_ch.ready drops only when both are full.
// Reset (rst_n low, synchronous): phase idle, not homed, phase start zero, both
// stages empty, registers at their defaults (settle 1 s, timeouts 120 s).
module stepper_homing_sequencer_core
  import shs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  shs_in_if.sink                    in_ch,
  shs_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata
);

  // setup registers
  logic signed [1:0]  dir_r;
  logic [23:0]        base_speed_r;
  logic [31:0]        adjust_dist_r;
  logic [31:0]        zero_pos_r;
  logic [TIME_W-1:0]  settle_r;
  logic [TIME_W-1:0]  toward_to_r;
  logic [TIME_W-1:0]  away_to_r;

  // sequencer state
  phase_t             phase_r, phase_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic               homed_r, homed_nxt;

  // input stage
  logic               s1_v_r;
  logic [1:0]         s1_cmd_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic               s1_limit_r;
  logic               s1_fault_r;
  logic               s1_busy_r;

  // result stage
  logic               out_v_r;
  logic [2:0]         o_phase_r;
  logic               o_jog_r, o_stop_r, o_rest_r, o_move_r, o_setp_r, o_homed_r;
  logic signed [24:0] o_speed_r;
  logic [31:0]        o_dist_r, o_pos_r;

  // combinational results
  logic               jog_nxt, stop_nxt, rest_nxt, move_nxt, setp_nxt;
  logic signed [24:0] speed_nxt;
  logic [31:0]        dist_nxt, pos_nxt;

  logic               adv;
  logic               in_take;
  logic               dir_pos, dir_neg, dir_on;
  logic [TIME_W-1:0]  elapsed;
  logic [48:0]        prod5;
  logic [21:0]        fifth;
  logic signed [24:0] fwd_speed, back_speed;

  // handshake: the input stage moves on when the result stage is free
  assign adv     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_v_r || adv;

  // direction decode; minus two counts as backward
  assign dir_pos = (dir_r == 2'sd1);
  assign dir_neg = dir_r[1];
  assign dir_on  = dir_pos || dir_neg;

  // jog speeds: full speed toward, a fifth of it backing off
  assign prod5      = 49'(base_speed_r) * 49'(RECIP5);
  assign fifth      = prod5[RECIP5_SH +: 22];
  assign fwd_speed  = dir_pos ? $signed({1'b0, base_speed_r})
                    : (dir_neg ? -$signed({1'b0, base_speed_r}) : 25'sd0);
  assign back_speed = dir_pos ? -$signed({3'b000, fifth})
                    : (dir_neg ? $signed({3'b000, fifth}) : 25'sd0);

  assign elapsed = s1_now_r - start_r;

  // sequencer step for the word in the input stage
  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    homed_nxt = homed_r;
    jog_nxt   = 1'b0;
    speed_nxt = 25'sd0;
    stop_nxt  = 1'b0;
    rest_nxt  = 1'b0;
    move_nxt  = 1'b0;
    dist_nxt  = 32'd0;
    setp_nxt  = 1'b0;
    pos_nxt   = 32'd0;
    if (s1_cmd_r == CMD_START) begin
      homed_nxt = 1'b0;
      jog_nxt   = 1'b1;
      speed_nxt = fwd_speed;
      phase_nxt = PH_TOWARD;
      start_nxt = s1_now_r;
    end else if (s1_cmd_r == CMD_STOP) begin
      stop_nxt  = 1'b1;
      phase_nxt = PH_IDLE;
      start_nxt = s1_now_r;
    end else if (s1_cmd_r == CMD_EVAL && dir_on) begin
      if (s1_fault_r && phase_r != PH_IDLE && phase_r != PH_ERROR) begin
        phase_nxt = PH_ERROR;
        start_nxt = s1_now_r;
      end else begin
        case (phase_r)
          PH_TOWARD: begin
            // a switch hit restarts the phase clock before the timeout check
            if (s1_limit_r) begin
              stop_nxt  = 1'b1;
              start_nxt = s1_now_r;
              phase_nxt = (toward_to_r == '0) ? PH_ERROR : PH_DELAY1;
            end else if (elapsed >= toward_to_r) begin
              start_nxt = s1_now_r;
              phase_nxt = PH_ERROR;
            end
          end
          PH_DELAY1: begin
            if (elapsed >= settle_r) begin
              phase_nxt = PH_AWAY;
              start_nxt = s1_now_r;
              jog_nxt   = 1'b1;
              speed_nxt = back_speed;
            end
          end
          PH_AWAY: begin
            if (!s1_limit_r) begin
              stop_nxt  = 1'b1;
              start_nxt = s1_now_r;
              phase_nxt = (away_to_r == '0) ? PH_ERROR : PH_DELAY2;
            end else if (elapsed >= away_to_r) begin
              start_nxt = s1_now_r;
              phase_nxt = PH_ERROR;
            end
          end
          PH_DELAY2: begin
            if (elapsed >= settle_r) begin
              phase_nxt = PH_ADJUST;
              start_nxt = s1_now_r;
              rest_nxt  = 1'b1;
              move_nxt  = 1'b1;
              dist_nxt  = adjust_dist_r;
            end
          end
          PH_ADJUST: begin
            if (!s1_busy_r) begin
              phase_nxt = PH_DELAY3;
              start_nxt = s1_now_r;
            end
          end
          PH_DELAY3: begin
            if (elapsed >= settle_r) begin
              phase_nxt = PH_IDLE;
              start_nxt = s1_now_r;
              setp_nxt  = 1'b1;
              pos_nxt   = zero_pos_r;
              homed_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // setup register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r         <= 2'sd0;
      base_speed_r  <= '0;
      adjust_dist_r <= '0;
      zero_pos_r    <= '0;
      settle_r      <= SETTLE_RST;
      toward_to_r   <= TIMEOUT_RST;
      away_to_r     <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIRECTION:   dir_r         <= $signed(cfg_wdata[1:0]);
        CFG_BASE_SPEED:  base_speed_r  <= cfg_wdata[23:0];
        CFG_ADJUST_DIST: adjust_dist_r <= cfg_wdata;
        CFG_ZERO_POS:    zero_pos_r    <= cfg_wdata;
        CFG_SETTLE:      settle_r      <= cfg_wdata;
        CFG_TOWARD_TO:   toward_to_r   <= cfg_wdata;
        CFG_AWAY_TO:     away_to_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer state and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      start_r <= '0;
      homed_r <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv) begin
        phase_r <= phase_nxt;
        start_r <= start_nxt;
        homed_r <= homed_nxt;
      end
      if (in_take) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // capture the incoming word
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r   <= in_ch.command;
      s1_now_r   <= in_ch.now_us;
      s1_limit_r <= in_ch.limit_switch;
      s1_fault_r <= in_ch.fault;
      s1_busy_r  <= in_ch.motion_busy;
    end
  end

  // load the result word
  always_ff @(posedge clk) begin
    if (adv) begin
      o_phase_r <= phase_code(phase_nxt);
      o_jog_r   <= jog_nxt;
      o_speed_r <= speed_nxt;
      o_stop_r  <= stop_nxt;
      o_rest_r  <= rest_nxt;
      o_move_r  <= move_nxt;
      o_dist_r  <= dist_nxt;
      o_setp_r  <= setp_nxt;
      o_pos_r   <= pos_nxt;
      o_homed_r <= homed_nxt;
    end
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.phase              = o_phase_r;
  assign out_ch.jog_valid          = o_jog_r;
  assign out_ch.jog_speed          = o_speed_r;
  assign out_ch.stop_motor         = o_stop_r;
  assign out_ch.restore_defaults   = o_rest_r;
  assign out_ch.move_valid         = o_move_r;
  assign out_ch.move_distance      = $signed(o_dist_r);
  assign out_ch.set_position_valid = o_setp_r;
  assign out_ch.set_position_value = $signed(o_pos_r);
  assign out_ch.homed              = o_homed_r;

  // checks
`include "stepper_homing_sequencer_core_assert.svh"

  `SHS_ASSERT_NOW(a_ready_only_on_full, !in_ch.ready, s1_v_r && out_v_r && !out_ch.ready, "input stalled with room to spare")
  `SHS_ASSERT_NXT(a_start_enters_toward, adv && s1_cmd_r == CMD_START, phase_r == PH_TOWARD && !homed_r && out_ch.jog_valid, "start did not enter toward")
  `SHS_ASSERT_NXT(a_fault_to_error, adv && s1_cmd_r == CMD_EVAL && dir_on && s1_fault_r && phase_r != PH_IDLE && phase_r != PH_ERROR, phase_r == PH_ERROR && !out_ch.stop_motor && !out_ch.jog_valid, "fault did not enter error quietly")
  `SHS_ASSERT_NOW(a_setpos_homed, out_ch.valid && out_ch.set_position_valid, out_ch.homed && out_ch.phase == PC_IDLE, "set position without homed idle")

endmodule
`default_nettype wire
